// ----- hw/rtl/ftc_pkg.sv -----
// Flow statistics traffic classifier: shared types, constants and helpers.
// Used by ftc_div, the top level and the checker; depends on nothing.
package ftc_pkg;

  localparam int FLOWS_DEFAULT = 256;

  // Divider operand widths.
  localparam int DVD_W = 54;
  localparam int DVS_W = 49;
  localparam int SH_W  = 58;
  localparam int QUO_W = 24;
  localparam int STP_W = 5;

  // Traffic class codes.
  localparam logic [2:0] CLS_UNKNOWN   = 3'd0;
  localparam logic [2:0] CLS_GAMING    = 3'd1;
  localparam logic [2:0] CLS_VOIP      = 3'd2;
  localparam logic [2:0] CLS_STREAMING = 3'd3;
  localparam logic [2:0] CLS_FILE      = 3'd4;
  localparam logic [2:0] CLS_BROWSING  = 3'd5;

  localparam logic [6:0] CONF_MAX = 7'd100;
  localparam logic [47:0] GAP_LIMIT_US = 48'd10000000;
  localparam logic [15:0] SMALL_BYTES = 16'd100;
  // Gap sample floor(d * 256 / 1000) = floor(d * GAP_RECIP / 2^31), with
  // GAP_RECIP = ceil(2^36 / 125); exact for every gap below 2^24 us.
  localparam logic [29:0] GAP_RECIP = 30'd549755814;

  typedef struct packed {
    logic        valid;
    logic [47:0] fwd_bytes;
    logic [47:0] bwd_bytes;
    logic [31:0] fwd_pkts;
    logic [31:0] bwd_pkts;
    logic [31:0] small_cnt;
    logic [23:0] avg_size;
    logic [15:0] min_size;
    logic [15:0] max_size;
    logic [21:0] avg_gap;
    logic [31:0] gap_samples;
    logic [47:0] last_time;
  } flow_entry_t;

  typedef struct packed {
    logic             start;
    logic [STP_W-1:0] steps;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] v, input logic [15:0] a);
    logic [48:0] s;
    s = {1'b0, v} + 49'(a);
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic flow_entry_t open_entry();
    flow_entry_t e;
    e = '0;
    e.valid = 1'b1;
    e.min_size = 16'hFFFF;
    return e;
  endfunction

endpackage

// ----- hw/rtl/ftc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ftc_div.sv -----
// Shared restoring divider, one quotient bit per cycle, bit count chosen per request.
// Depends on ftc_pkg.
module ftc_div import ftc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [STP_W-1:0] cnt;
  logic [SH_W-1:0]  rem;
  logic [SH_W-1:0]  dsh;
  logic [QUO_W-1:0] quo;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STP_W'(1);
        if (cnt == STP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the divisor down one place per step; subtract where it fits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= SH_W'(req.dividend);
      dsh <= SH_W'(req.divisor) << (req.steps - STP_W'(1));
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? rem - dsh : rem;
      dsh <= dsh >> 1;
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- hw/rtl/flow_statistics_traffic_classifier.sv -----
// Flow statistics traffic classifier: top level with per-flow table and FSM.
// Depends on ftc_pkg, ftc_ram and ftc_div.
//
//   channel  | handshake           | beat contents
//   ---------+---------------------+------------------------------------------------
//   input    | in_valid / in_ready | new_flow, flow_index, addresses, size, timestamp
//   output   | out_valid/out_ready | class, confidence, flow statistics
//
// One packet at a time. After the accept a packet passes S_LOAD, a size
// average division (S_SZ), a gap average division (S_GC, S_GA) only when it
// gives a gap sample, S_CLS, a confidence division (S_CD) only for a gaming or
// streaming class, S_WB and S_OUT, where its result is registered. Every
// division runs on the shared one-bit-per-cycle divider; the gap sample itself
// comes from a reciprocal multiply. in_ready rises as the result is registered.
// After reset the table is swept once and in_ready stays low meanwhile. A
// finished result waits in the output register while the next packet is
// accepted and worked on; a second result holds until the first beat leaves.
module flow_statistics_traffic_classifier import ftc_pkg::*; #(
  parameter int FLOWS = FLOWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        new_flow,
  input  logic [7:0]  flow_index,
  input  logic [31:0] source_address,
  input  logic [31:0] flow_origin_address,
  input  logic [15:0] packet_bytes,
  input  logic [47:0] timestamp_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  traffic_class,
  output logic [6:0]  confidence_percent,
  output logic        too_few_packets,
  output logic [23:0] average_size,
  output logic [21:0] average_gap_ms,
  output logic [31:0] packet_total,
  output logic [15:0] smallest_size,
  output logic [15:0] largest_size
);

  localparam int AW = $clog2(FLOWS);
  localparam int EW = $bits(flow_entry_t);
  localparam int PW = 57;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_SZ, S_GC, S_GA, S_CLS, S_CD, S_WB, S_OUT
  } state_t;

  state_t state;

  // Map the flow index onto the table.
  logic [AW-1:0] k;
  generate
    if (FLOWS >= 256) begin : g_direct
      assign k = AW'(flow_index);
    end else begin : g_mod
      logic [AW-1:0] mod_tab [256];
      for (genvar i = 0; i < 256; i++) begin : g_tab
        assign mod_tab[i] = AW'(i % FLOWS);
      end
      assign k = mod_tab[flow_index];
    end
  endgenerate

  // Packet registers.
  logic [AW-1:0] kreg;
  logic          nf_r;
  logic          fwd_r;
  logic [15:0]   size_r;
  logic [47:0]   t_r;
  logic [AW-1:0] clr_addr;

  // Working copy of the entry.
  flow_entry_t w;
  logic        gap_ok;
  logic [23:0] gap_d;
  logic        div_neg;
  logic [6:0]  conf_base;

  flow_entry_t rdata;
  flow_entry_t wdata;
  logic        ram_we;
  logic [AW-1:0] waddr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic out_load;

  assign in_ready = (state == S_IDLE);
  // Load the output register when it is empty or its beat leaves now.
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  assign ram_we = (state == S_CLEAR) || (state == S_WB);
  assign waddr  = (state == S_CLEAR) ? clr_addr : kreg;
  assign wdata  = (state == S_CLEAR) ? flow_entry_t'('0) : w;

  ftc_ram #(.WIDTH(EW), .DEPTH(FLOWS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_valid && in_ready),
    .raddr (k),
    .rdata (rdata)
  );

  ftc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Entry as read, reopened when asked or never used.
  flow_entry_t ent;
  flow_entry_t w_load;
  logic [23:0] x_size;
  logic        size_neg;
  logic [33:0] n1;
  logic [47:0] d_full;
  logic        gap_hit;

  always_comb begin
    ent      = (nf_r || !rdata.valid) ? open_entry() : rdata;
    x_size   = {size_r, 8'h00};
    size_neg = x_size < ent.avg_size;
    n1       = 34'(ent.fwd_pkts) + 34'(ent.bwd_pkts) + 34'd1;
    d_full   = t_r - ent.last_time;
    gap_hit  = (ent.last_time != '0) && (t_r > ent.last_time) && (d_full < GAP_LIMIT_US);
  end

  // Count the packet; averages follow from the divider.
  always_comb begin
    w_load = ent;
    if (size_r < ent.min_size) w_load.min_size = size_r;
    if (size_r > ent.max_size) w_load.max_size = size_r;
    if (fwd_r) begin
      w_load.fwd_bytes = sat_add48(ent.fwd_bytes, size_r);
      w_load.fwd_pkts  = sat_inc32(ent.fwd_pkts);
    end else begin
      w_load.bwd_bytes = sat_add48(ent.bwd_bytes, size_r);
      w_load.bwd_pkts  = sat_inc32(ent.bwd_pkts);
    end
    if (size_r < SMALL_BYTES) w_load.small_cnt = sat_inc32(ent.small_cnt);
    w_load.last_time = t_r;
  end

  // Gap sample by reciprocal multiply, and its running average.
  logic [53:0] gap_prod;
  logic [21:0] g_smp;
  logic [31:0] gs_inc;
  logic        gap_neg;
  assign gap_prod = 54'(gap_d) * 54'(GAP_RECIP);
  assign gs_inc   = sat_inc32(w.gap_samples);
  assign gap_neg  = g_smp < w.avg_gap;

  // Classification terms.
  logic [32:0]   n2;
  logic          tb_zero;
  logic [48:0]   bb;
  logic [48:0]   tb;
  logic [PW-1:0] bbx, tbx, scx, nx;
  logic          few, is_game, is_voip, is_stream, is_file, is_brow;

  always_comb begin
    n2      = 33'(w.fwd_pkts) + 33'(w.bwd_pkts);
    tb_zero = (w.fwd_bytes == '0) && (w.bwd_bytes == '0);
    bb      = tb_zero ? 49'd1 : 49'(w.bwd_bytes);
    tb      = tb_zero ? 49'd2 : 49'(w.fwd_bytes) + 49'(w.bwd_bytes);
    bbx     = PW'(bb);
    tbx     = PW'(tb);
    scx     = PW'(w.small_cnt);
    nx      = PW'(n2);
    few     = n2 < 33'd3;
    is_game = (w.avg_size < 24'(150 * 256)) && (w.avg_gap < 22'(50 * 256)) &&
              (2 * scx > nx) && (10 * bbx > 3 * tbx) && (10 * bbx < 7 * tbx);
    is_voip = (w.avg_size < 24'(250 * 256)) && (w.avg_gap < 22'(30 * 256)) &&
              (100 * bbx > 35 * tbx) && (100 * bbx < 65 * tbx);
    is_stream = (w.avg_size > 24'(800 * 256)) && (4 * bbx > 3 * tbx) && (5 * scx < nx);
    is_file = (w.avg_size > 24'(800 * 256)) && (n2 > 33'd10) && (20 * scx < 3 * nx);
    is_brow = (w.avg_size > 24'(200 * 256)) && (w.avg_size < 24'(900 * 256)) &&
              (20 * bbx > 11 * tbx);
  end

  // Divider requests by phase.
  always_comb begin
    div_req = '0;
    unique case (state)
      S_LOAD: begin
        div_req.start    = 1'b1;
        div_req.steps    = STP_W'(24);
        div_req.dividend = DVD_W'(size_neg ? ent.avg_size - x_size : x_size - ent.avg_size);
        div_req.divisor  = DVS_W'(n1);
      end
      S_GC: begin
        div_req.start    = 1'b1;
        div_req.steps    = STP_W'(22);
        div_req.dividend = DVD_W'(gap_neg ? w.avg_gap - g_smp : g_smp - w.avg_gap);
        div_req.divisor  = DVS_W'(gs_inc);
      end
      S_CLS: begin
        div_req.start = !few && (is_game || (!is_voip && is_stream));
        div_req.steps = STP_W'(7);
        if (is_game) begin
          div_req.dividend = DVD_W'(50 * scx);
          div_req.divisor  = DVS_W'(n2);
        end else begin
          div_req.dividend = DVD_W'(60 * bbx);
          div_req.divisor  = tb;
        end
      end
      default: div_req = '0;
    endcase
  end

  logic [7:0] conf_sum;
  assign conf_sum = 8'(conf_base) + 8'(div_rsp.quotient[6:0]);

  logic [2:0] cls_r;
  logic [6:0] conf_r;

  // Control state and packet sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(FLOWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: state <= S_SZ;
        S_SZ: begin
          if (div_rsp.done) begin
            state <= gap_ok ? S_GC : S_CLS;
          end
        end
        S_GC: state <= S_GA;
        S_GA: begin
          if (div_rsp.done) begin
            state <= S_CLS;
          end
        end
        S_CLS: state <= div_req.start ? S_CD : S_WB;
        S_CD: begin
          if (div_rsp.done) begin
            state <= S_WB;
          end
        end
        S_WB: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        kreg   <= k;
        nf_r   <= new_flow;
        fwd_r  <= (source_address == flow_origin_address);
        size_r <= packet_bytes;
        t_r    <= timestamp_us;
      end
      S_LOAD: begin
        w       <= w_load;
        gap_ok  <= gap_hit;
        gap_d   <= d_full[23:0];
        div_neg <= size_neg;
      end
      S_SZ: begin
        g_smp <= gap_prod[52:31];
        if (div_rsp.done) begin
          w.avg_size <= div_neg ? w.avg_size - div_rsp.quotient
                                : w.avg_size + div_rsp.quotient;
        end
      end
      S_GC: begin
        w.gap_samples <= gs_inc;
        div_neg       <= gap_neg;
      end
      S_GA: begin
        if (div_rsp.done) begin
          w.avg_gap <= div_neg ? w.avg_gap - div_rsp.quotient[21:0]
                               : w.avg_gap + div_rsp.quotient[21:0];
        end
      end
      S_CLS: begin
        if (few) begin
          cls_r     <= CLS_UNKNOWN;
          conf_r    <= '0;
          conf_base <= '0;
        end else if (is_game) begin
          cls_r     <= CLS_GAMING;
          conf_r    <= '0;
          conf_base <= 7'd50;
        end else if (is_voip) begin
          cls_r     <= CLS_VOIP;
          conf_r    <= 7'd80;
          conf_base <= '0;
        end else if (is_stream) begin
          cls_r     <= CLS_STREAMING;
          conf_r    <= '0;
          conf_base <= 7'd25;
        end else if (is_file) begin
          cls_r     <= CLS_FILE;
          conf_r    <= 7'd70;
          conf_base <= '0;
        end else if (is_brow) begin
          cls_r     <= CLS_BROWSING;
          conf_r    <= 7'd65;
          conf_base <= '0;
        end else begin
          cls_r     <= CLS_UNKNOWN;
          conf_r    <= '0;
          conf_base <= '0;
        end
      end
      S_CD: begin
        if (div_rsp.done) begin
          conf_r <= (conf_sum > 8'(CONF_MAX)) ? CONF_MAX : conf_sum[6:0];
        end
      end
      S_OUT: begin
        if (out_load) begin
          traffic_class      <= cls_r;
          confidence_percent <= conf_r;
          too_few_packets    <= few;
          average_size       <= w.avg_size;
          average_gap_ms     <= w.avg_gap;
          packet_total       <= n2[32] ? 32'hFFFF_FFFF : n2[31:0];
          smallest_size      <= w.min_size;
          largest_size       <= w.max_size;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/ftc_checker.sv -----
// Port-level checks for the flow statistics traffic classifier, bound to the top level.
// Depends on ftc_pkg and flow_statistics_traffic_classifier.
module ftc_checker import ftc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  traffic_class,
  input logic [6:0]  confidence_percent,
  input logic        too_few_packets,
  input logic [31:0] packet_total,
  input logic [15:0] smallest_size,
  input logic [15:0] largest_size
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(traffic_class) &&
      $stable(confidence_percent) && $stable(packet_total))
    else $error("result beat dropped or changed while stalled");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> confidence_percent <= CONF_MAX && traffic_class <= CLS_BROWSING)
    else $error("class or confidence out of range");

  a_few: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_few_packets |-> traffic_class == CLS_UNKNOWN &&
      confidence_percent == 7'd0 && packet_total < 32'd3)
    else $error("short flow classified");

  a_enough: assert property (@(posedge clk) disable iff (rst)
    out_valid && !too_few_packets |-> packet_total >= 32'd3 &&
      smallest_size <= largest_size)
    else $error("flow statistics inconsistent");

endmodule

bind flow_statistics_traffic_classifier ftc_checker u_ftc_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .traffic_class      (traffic_class),
  .confidence_percent (confidence_percent),
  .too_few_packets    (too_few_packets),
  .packet_total       (packet_total),
  .smallest_size      (smallest_size),
  .largest_size       (largest_size)
);

// ----- sim/tb_top.sv -----
// Testbench for flow_statistics_traffic_classifier: per-flow statistics and classification.
// Self-checking against an in-bench predictor of the flow table; depends on ftc_pkg and the RTL.
module tb_top import ftc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFLOWS = 256;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic new_flow = 1'b0;
  logic [7:0] flow_index = '0;
  logic [31:0] source_address = '0;
  logic [31:0] flow_origin_address = '0;
  logic [15:0] packet_bytes = '0;
  logic [47:0] timestamp_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] traffic_class;
  logic [6:0] confidence_percent;
  logic too_few_packets;
  logic [23:0] average_size;
  logic [21:0] average_gap_ms;
  logic [31:0] packet_total;
  logic [15:0] smallest_size;
  logic [15:0] largest_size;

  typedef struct packed {
    logic [2:0] cls;
    logic [6:0] conf;
    logic few;
    logic [23:0] avg_size;
    logic [21:0] avg_gap;
    logic [31:0] total;
    logic [15:0] min_size;
    logic [15:0] max_size;
  } flow_verdict_t;

  flow_verdict_t verdicts_pending[$];
  flow_entry_t flow_table[NFLOWS];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  longint cycle_count = 0;
  // per-flow clock so that timestamps advance realistically
  logic [47:0] flow_clock[NFLOWS];

  flow_statistics_traffic_classifier #(.FLOWS(NFLOWS)) DUT (.*);

  always #6 clk = ~clk;

  // Hard stop if the design hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Running-average step with floor division toward the old value.
  function automatic logic [31:0] avg_step(logic [31:0] avg, logic [31:0] x, logic [63:0] n);
    if (n == 0) n = 1;
    if (x >= avg) return avg + 32'((64'(x - avg)) / n);
    return avg - 32'((64'(avg - x)) / n);
  endfunction

  // Fold one packet into the shadow table and compute its classification.
  function automatic flow_verdict_t classify_packet(logic nf, logic [7:0] idx, logic [31:0] src,
      logic [31:0] org, logic [15:0] size, logic [47:0] ts);
    flow_entry_t e;
    flow_verdict_t v;
    logic [63:0] n, bb, tb, sc, d, conf;
    logic [31:0] g;
    e = flow_table[idx % NFLOWS];
    if (nf || !e.valid) begin
      e = '0;
      e.valid = 1'b1;
      e.min_size = 16'hFFFF;
    end
    n = 64'(e.fwd_pkts) + 64'(e.bwd_pkts) + 1;
    e.avg_size = 24'(avg_step(32'(e.avg_size), 32'(size) << 8, n));
    if (size < e.min_size) e.min_size = size;
    if (size > e.max_size) e.max_size = size;
    if (src == org) begin
      e.fwd_bytes = (e.fwd_bytes + 49'(size) > 49'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF
                    : e.fwd_bytes + 48'(size);
      if (e.fwd_pkts != 32'hFFFF_FFFF) e.fwd_pkts++;
    end else begin
      e.bwd_bytes = (e.bwd_bytes + 49'(size) > 49'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF
                    : e.bwd_bytes + 48'(size);
      if (e.bwd_pkts != 32'hFFFF_FFFF) e.bwd_pkts++;
    end
    if (e.last_time != 0 && ts > e.last_time) begin
      d = 64'(ts - e.last_time);
      if (d < 64'd10000000) begin
        g = 32'((d * 256) / 1000);
        if (e.gap_samples != 32'hFFFF_FFFF) e.gap_samples++;
        e.avg_gap = 22'(avg_step(32'(e.avg_gap), g, 64'(e.gap_samples)));
      end
    end
    e.last_time = ts;
    if (size < 100 && e.small_cnt != 32'hFFFF_FFFF) e.small_cnt++;
    flow_table[idx % NFLOWS] = e;

    n = 64'(e.fwd_pkts) + 64'(e.bwd_pkts);
    v = '0;
    v.cls = CLS_UNKNOWN;
    v.total = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(n);
    v.avg_size = e.avg_size;
    v.avg_gap = e.avg_gap;
    v.min_size = e.min_size;
    v.max_size = e.max_size;
    if (n < 3) begin
      v.few = 1'b1;
    end else begin
      bb = 64'(e.bwd_bytes);
      tb = 64'(e.fwd_bytes) + 64'(e.bwd_bytes);
      if (tb == 0) begin
        bb = 1;
        tb = 2;
      end
      sc = 64'(e.small_cnt);
      conf = 0;
      if (e.avg_size < 150 * 256 && e.avg_gap < 50 * 256 && 2 * sc > n
          && 10 * bb > 3 * tb && 10 * bb < 7 * tb) begin
        v.cls = CLS_GAMING;
        conf = 50 + (50 * sc) / n;
      end else if (e.avg_size < 250 * 256 && e.avg_gap < 30 * 256
                   && 100 * bb > 35 * tb && 100 * bb < 65 * tb) begin
        v.cls = CLS_VOIP;
        conf = 80;
      end else if (e.avg_size > 800 * 256 && 4 * bb > 3 * tb && 5 * sc < n) begin
        v.cls = CLS_STREAMING;
        conf = 25 + (60 * bb) / tb;
      end else if (e.avg_size > 800 * 256 && n > 10 && 20 * sc < 3 * n) begin
        v.cls = CLS_FILE;
        conf = 70;
      end else if (e.avg_size > 200 * 256 && e.avg_size < 900 * 256 && 20 * bb > 11 * tb) begin
        v.cls = CLS_BROWSING;
        conf = 65;
      end
      v.conf = (conf > 100) ? CONF_MAX : 7'(conf);
    end
    return v;
  endfunction

  // Drive one packet beat, random gap first, and hold until accepted.
  task automatic send_packet(logic nf, logic [7:0] idx, logic [31:0] src, logic [31:0] org,
      logic [15:0] size, logic [47:0] ts);
    flow_verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    new_flow <= nf;
    flow_index <= idx;
    source_address <= src;
    flow_origin_address <= org;
    packet_bytes <= size;
    timestamp_us <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = classify_packet(nf, idx, src, org, size, ts);
    verdicts_pending.insert(verdicts_pending.size(), v);
    beats_sent++;
    // drop valid before the next beat
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, compare each result with the oldest prediction.
  always @(posedge clk) begin
    flow_verdict_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (verdicts_pending.size() == 0) begin
          $error("result beat with no packet outstanding");
          errors++;
        end else begin
          want = verdicts_pending.pop_front();
          beats_checked++;
          if (traffic_class !== want.cls) begin
            $error("traffic_class exp %0d got %0d", want.cls, traffic_class); errors++;
          end
          if (confidence_percent !== want.conf) begin
            $error("confidence_percent exp %0d got %0d", want.conf, confidence_percent); errors++;
          end
          if (too_few_packets !== want.few) begin
            $error("too_few_packets exp %0d got %0d", want.few, too_few_packets); errors++;
          end
          if (average_size !== want.avg_size) begin
            $error("average_size exp %0h got %0h", want.avg_size, average_size); errors++;
          end
          if (average_gap_ms !== want.avg_gap) begin
            $error("average_gap_ms exp %0h got %0h", want.avg_gap, average_gap_ms); errors++;
          end
          if (packet_total !== want.total) begin
            $error("packet_total exp %0d got %0d", want.total, packet_total); errors++;
          end
          if (smallest_size !== want.min_size) begin
            $error("smallest_size exp %0d got %0d", want.min_size, smallest_size); errors++;
          end
          if (largest_size !== want.max_size) begin
            $error("largest_size exp %0d got %0d", want.max_size, largest_size); errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic drain_results();
    while (verdicts_pending.size() != 0) @(posedge clk);
  endtask

  // Send one packet on a flow, advancing that flow's clock by dt.
  task automatic flow_packet(logic nf, logic [7:0] idx, logic fwd, logic [15:0] size,
      logic [47:0] dt);
    logic [31:0] org;
    org = {8'd10, 16'd0, idx};
    flow_clock[idx] = flow_clock[idx] + dt;
    send_packet(nf, idx, fwd ? org : ~org, org, size, flow_clock[idx]);
  endtask

  // Field extremes, zero timestamps, wrap and too-large gaps.
  task automatic test_directed_extremes();
    send_packet(1'b0, 8'd0, 32'h0, 32'h0, 16'd0, 48'd0);
    send_packet(1'b0, 8'd0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_packet(1'b0, 8'd0, 32'h0, 32'h0, 16'd99, 48'hFFFF_FFFF_FFFE);   // time going back
    send_packet(1'b0, 8'd0, 32'h0, 32'h0, 16'd100, 48'd0);               // zero time
    send_packet(1'b1, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 48'd1);
    send_packet(1'b0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 48'd1);  // zero delta
    send_packet(1'b0, 8'd255, 32'h1234_5678, 32'hFFFF_FFFF, 16'd1, 48'd10000001); // 10 s
    send_packet(1'b0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 48'd19999999); // just under
    send_packet(1'b1, 8'd255, 32'h0, 32'h0, 16'd500, 48'd5);             // reopen a live flow
  endtask

  // Well-formed sequences shaped toward each traffic class.
  task automatic test_directed_classes();
    logic [7:0] f;
    for (int c = 0; c < 6; c++) begin
      f = 8'(100 + c);
      flow_clock[f] = 48'd1000;
      for (int i = 0; i < 13; i++) begin
        case (c)
          0: flow_packet(i == 0, f, i[0], 16'd60, 48'd20000);      // gaming
          1: flow_packet(i == 0, f, i[0], 16'd180, 48'd20000);     // voip
          2: flow_packet(i == 0, f, (i % 5) == 0, 16'd1400, 48'd3000); // streaming
          3: flow_packet(i == 0, f, 1'b1, 16'd1500, 48'd100000);   // file transfer
          4: flow_packet(i == 0, f, (i % 3) == 0, 16'd500, 48'd900000); // browsing
          default: flow_packet(i == 0, f, 1'b1, 16'd300, 48'd0);  // no match
        endcase
      end
    end
  endtask

  // Random traffic: mostly class-shaped bursts on a small set of flows, some noise.
  task automatic test_random_traffic(int count);
    logic [7:0] f;
    int kind, len;
    int done_cnt;
    done_cnt = 0;
    while (done_cnt < count) begin
      if ($urandom_range(9) < 8) begin
        f = 8'($urandom_range(15));
        kind = $urandom_range(4);
        len = $urandom_range(3, 20);
        for (int i = 0; i < len; i++) begin
          case (kind)
            0: flow_packet(i == 0, f, 1'($urandom_range(1)), 16'($urandom_range(40, 140)),
                           48'($urandom_range(1000, 60000)));
            1: flow_packet(i == 0, f, 1'($urandom_range(1)), 16'($urandom_range(60, 260)),
                           48'($urandom_range(5000, 40000)));
            2: flow_packet(i == 0, f, $urandom_range(9) == 0, 16'($urandom_range(700, 1500)),
                           48'($urandom_range(100, 20000)));
            3: flow_packet(i == 0, f, $urandom_range(9) != 0, 16'($urandom_range(700, 1500)),
                           48'($urandom_range(100, 20000000)));
            default: flow_packet(i == 0, f, $urandom_range(2) == 0,
                                 16'($urandom_range(150, 1000)), 48'($urandom_range(0, 2000000)));
          endcase
          done_cnt++;
        end
      end else begin
        send_packet(1'($urandom_range(1)), 8'($urandom), $urandom, $urandom, 16'($urandom),
                    {16'($urandom), 32'($urandom)});
        done_cnt++;
      end
    end
  endtask

  // Sender holds off until every result is back, then continues.
  task automatic test_quiet_pause();
    flow_packet(1'b1, 8'd200, 1'b1, 16'd64, 48'd7);
    drain_results();
    flow_packet(1'b0, 8'd200, 1'b0, 16'd64, 48'd20000);
    flow_packet(1'b0, 8'd200, 1'b1, 16'd64, 48'd20000);
  endtask

  initial begin
    for (int i = 0; i < NFLOWS; i++) begin
      flow_table[i] = '0;
      flow_clock[i] = 48'd1;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_directed_classes();
    test_quiet_pause();
    send_idle_pct = 30;
    recv_idle_pct = 55;
    test_random_traffic(600);
    send_idle_pct = 55;
    recv_idle_pct = 30;
    test_random_traffic(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(600);
    drain_results();
    repeat (100) @(posedge clk);
    $display("sent %0d packets, checked %0d results across directed, class-shaped and random traffic",
             beats_sent, beats_checked);
    if (errors == 0 && verdicts_pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/ftc_pkg.sv
hw/rtl/ftc_ram.sv
hw/rtl/ftc_div.sv
hw/rtl/flow_statistics_traffic_classifier.sv
hw/rtl/ftc_checker.sv
sim/tb_top.sv
